/* hw/rtl/pott_pkg.sv */
// Shared types and constants for the periodic / one-shot timer table.
// Used by pott_cell, pott_slot_update and periodic_oneshot_timer_table_unit.
`default_nettype none
package pott_pkg;

   localparam int TABLE_SLOTS_DEFAULT = 16;

   localparam int OP_W     = 2;
   localparam int TIME_W   = 32;
   localparam int SLOT_W   = 4;
   localparam int PERIOD_W = 31;
   localparam int MASK_W   = 4;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // operation codes
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_CREATE = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_FIRE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd2;

   // reply status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_SCHED  = 2'd3;

   // change mask bit positions
   localparam int MASK_ENABLE = 0;
   localparam int MASK_ONCE   = 1;
   localparam int MASK_AT     = 2;
   localparam int MASK_PERIOD = 3;

   typedef struct packed {
      logic                valid;
      logic                enabled;
      logic                once;
      logic [TIME_W-1:0]   at_time;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   next_due;
   } slot_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [TIME_W-1:0]   now_time;
      logic [SLOT_W-1:0]   slot;
      logic [TIME_W-1:0]   at_time;
      logic [PERIOD_W-1:0] period;
      logic                enable_in;
      logic                once_in;
      logic [MASK_W-1:0]   change_mask;
   } req_type;

   // Per-slot action selected by the sequencer for the slot at the head.
   typedef struct packed {
      logic take_free;   // create lands in this slot
      logic hit;         // delete/update targets this slot
   } sel_type;

   typedef struct packed {
      slot_type          next;
      logic              fire;
      logic [TIME_W-1:0] due;
   } upd_type;

endpackage
`default_nettype wire

/* hw/rtl/periodic_oneshot_timer_table_unit.sv */
// Timer slot table: a ring of TABLE_SLOTS slot cells that rotates once per request.
// Each request is held in the sequencer while the slot ring rotates once past the single
// update unit at its head; the ring holds while a firing slot waits for the result register.
// The summary or reply is then registered, and a new request is taken only once the sequencer
// is back in idle: req_stall stays high while a request is in flight.
// A tick also emits one fire result per firing slot during the rotation.
// Synchronous active-high reset empties the table (all slots free) and drops results.
`default_nettype none
module periodic_oneshot_timer_table_unit #(
   parameter int TABLE_SLOTS = pott_pkg::TABLE_SLOTS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic [pott_pkg::OP_W-1:0]        req_op,
   input  wire logic [pott_pkg::TIME_W-1:0]      req_now_time,
   input  wire logic [pott_pkg::SLOT_W-1:0]      req_slot,
   input  wire logic [pott_pkg::TIME_W-1:0]      req_at_time,
   input  wire logic [pott_pkg::PERIOD_W-1:0]    req_period,
   input  wire logic                             req_enable_in,
   input  wire logic                             req_once_in,
   input  wire logic [pott_pkg::MASK_W-1:0]      req_change_mask,
   // result channel
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic [pott_pkg::KIND_W-1:0]      rsp_kind,
   output      logic [pott_pkg::SLOT_W-1:0]      rsp_out_slot,
   output      logic [pott_pkg::STATUS_W-1:0]    rsp_status,
   output      logic [pott_pkg::TIME_W-1:0]      rsp_due_time,
   output      logic [pott_pkg::COUNT_W-1:0]     rsp_active_count,
   output      logic [pott_pkg::TIME_W-1:0]      rsp_earliest_due,
   output      logic                             rsp_last
);
   import pott_pkg::*;

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   req_type             req_ff, req_in;
   logic                found_ff, found_in;    // create has placed its slot
   logic                hit_ok_ff, hit_ok_in;  // delete/update target was valid
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [TIME_W-1:0]   due_ff, due_in;        // reply due time captured during the pass
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [TIME_W-1:0]   early_ff, early_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [SLOT_W-1:0]   oslot_ff, oslot_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [TIME_W-1:0]   odue_ff, odue_in;
   logic [COUNT_W-1:0]  ocnt_ff, ocnt_in;
   logic [TIME_W-1:0]   oearly_ff, oearly_in;
   logic                last_ff, last_in;

   slot_type cell_q [TABLE_SLOTS];
   slot_type cell_d [TABLE_SLOTS];
   sel_type  sel;
   upd_type  upd;

   logic accept, out_free, emit_fire, ring_shift, sched_given;

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign sched_given = (req_ff.at_time != '0) || (req_ff.period != '0);

   // slot ring: each cell takes its upper neighbor; the last cell takes the updated head
   for (genvar j = 0; j < TABLE_SLOTS; j++) begin : g_ring
      if (j == TABLE_SLOTS - 1) begin : g_tail
         assign cell_d[j] = upd.next;
      end else begin : g_body
         assign cell_d[j] = cell_q[j+1];
      end
      pott_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (ring_shift),
         .d     (cell_d[j]),
         .q     (cell_q[j])
      );
   end

   // head slot selection for the request in flight
   always_comb begin
      sel.take_free = (req_ff.op == OP_CREATE) && sched_given && !found_ff &&
                      !cell_q[0].valid;
      sel.hit       = ((req_ff.op == OP_DELETE) || (req_ff.op == OP_UPDATE)) &&
                      (CMP_W'(idx_ff) == CMP_W'(req_ff.slot));
   end

   pott_slot_update u_update (
      .head (cell_q[0]),
      .req  (req_ff),
      .sel  (sel),
      .res  (upd)
   );

   // a firing slot needs the output register; hold the ring until it is free
   assign emit_fire  = (state_ff == ST_RUN) && upd.fire;
   assign ring_shift = (state_ff == ST_RUN) && (!upd.fire || out_free);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      req_in    = req_ff;
      found_in  = found_ff;
      hit_ok_in = hit_ok_ff;
      pos_in    = pos_ff;
      due_in    = due_ff;
      cnt_in    = cnt_ff;
      early_in  = early_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_RUN;
               idx_in    = '0;
               req_in    = '{op: req_op, now_time: req_now_time, slot: req_slot,
                             at_time: req_at_time, period: req_period,
                             enable_in: req_enable_in, once_in: req_once_in,
                             change_mask: req_change_mask};
               found_in  = 1'b0;
               hit_ok_in = 1'b0;
               pos_in    = '0;
               due_in    = '0;
               cnt_in    = '0;
               early_in  = '0;
            end
         end
         ST_RUN: begin
            if (ring_shift) begin
               if (sel.take_free) begin
                  found_in = 1'b1;
                  pos_in   = idx_ff;
                  due_in   = upd.due;
               end
               if (sel.hit && cell_q[0].valid) begin
                  hit_ok_in = 1'b1;
                  due_in    = upd.due;
               end
               // fold the updated slot into the summary
               if (upd.next.valid && upd.next.enabled) begin
                  cnt_in = cnt_ff + COUNT_W'(1);
                  if ((upd.next.next_due != '0) &&
                      ((early_ff == '0) || (upd.next.next_due < early_ff))) begin
                     early_in = upd.next.next_due;
                  end
               end
               if (idx_ff == IDX_LAST) begin
                  idx_in   = '0;
                  state_in = ST_FINAL;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_FINAL: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register: fire results during the pass, summary or reply at the end
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      oslot_in     = oslot_ff;
      status_in    = status_ff;
      odue_in      = odue_ff;
      ocnt_in      = ocnt_ff;
      oearly_in    = oearly_ff;
      last_in      = last_ff;
      if (emit_fire && out_free) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_FIRE;
         oslot_in     = SLOT_W'(idx_ff);
         status_in    = STATUS_OK;
         odue_in      = upd.due;
         ocnt_in      = '0;
         oearly_in    = '0;
         last_in      = 1'b0;
      end else if ((state_ff == ST_FINAL) && out_free) begin
         rsp_valid_in = 1'b1;
         ocnt_in      = cnt_ff;
         oearly_in    = early_ff;
         last_in      = 1'b1;
         priority if (req_ff.op == OP_TICK) begin
            kind_in   = KIND_SUMMARY;
            oslot_in  = '0;
            status_in = STATUS_OK;
            odue_in   = '0;
         end else if (req_ff.op == OP_CREATE) begin
            kind_in   = KIND_REPLY;
            oslot_in  = found_ff ? SLOT_W'(pos_ff) : '0;
            odue_in   = found_ff ? due_ff : '0;
            if (!sched_given)    status_in = STATUS_NO_SCHED;
            else if (!found_ff)  status_in = STATUS_FULL;
            else                 status_in = STATUS_OK;
         end else begin
            kind_in   = KIND_REPLY;
            oslot_in  = req_ff.slot;
            status_in = hit_ok_ff ? STATUS_OK : STATUS_NOT_FOUND;
            odue_in   = (hit_ok_ff && (req_ff.op == OP_UPDATE)) ? due_ff : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         hit_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         hit_ok_ff    <= hit_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      pos_ff    <= pos_in;
      due_ff    <= due_in;
      cnt_ff    <= cnt_in;
      early_ff  <= early_in;
      kind_ff   <= kind_in;
      oslot_ff  <= oslot_in;
      status_ff <= status_in;
      odue_ff   <= odue_in;
      ocnt_ff   <= ocnt_in;
      oearly_ff <= oearly_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_out_slot     = oslot_ff;
   assign rsp_status       = status_ff;
   assign rsp_due_time     = odue_ff;
   assign rsp_active_count = ocnt_ff;
   assign rsp_earliest_due = oearly_ff;
   assign rsp_last         = last_ff;

endmodule
`default_nettype wire

/* hw/rtl/pott_cell.sv */
// One timer slot of the rotating slot ring.
// Depends on pott_pkg for slot_type.
`default_nettype none
module pott_cell (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic shift,
   input  wire pott_pkg::slot_type d,
   output pott_pkg::slot_type q
);
   import pott_pkg::*;

   logic                valid_ff, enabled_ff, once_ff;
   logic [TIME_W-1:0]   at_ff, due_ff;
   logic [PERIOD_W-1:0] period_ff;

   // flags clear on reset; time fields are written by create before use
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         enabled_ff <= 1'b0;
         once_ff    <= 1'b0;
      end else if (shift) begin
         valid_ff   <= d.valid;
         enabled_ff <= d.enabled;
         once_ff    <= d.once;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         at_ff     <= d.at_time;
         period_ff <= d.period;
         due_ff    <= d.next_due;
      end
   end

   assign q = '{valid: valid_ff, enabled: enabled_ff, once: once_ff,
                at_time: at_ff, period: period_ff, next_due: due_ff};

endmodule
`default_nettype wire

/* hw/rtl/pott_slot_update.sv */
// Next-state logic for the slot at the head of the ring.
// Depends on pott_pkg for slot, request and result types.
`default_nettype none
module pott_slot_update (
   input  wire pott_pkg::slot_type head,
   input  wire pott_pkg::req_type  req,
   input  wire pott_pkg::sel_type  sel,
   output pott_pkg::upd_type  res
);
   import pott_pkg::*;

   logic [PERIOD_W-1:0] per_sel;
   logic [TIME_W-1:0]   at_sel;
   logic [TIME_W:0]     sum;
   logic [TIME_W-1:0]   sat_sum;

   always_comb begin
      at_sel  = req.change_mask[MASK_AT] ? req.at_time : head.at_time;
      per_sel = head.period;
      unique case (req.op)
         OP_TICK:   per_sel = head.period;
         OP_CREATE: per_sel = req.period;
         default:   per_sel = req.change_mask[MASK_PERIOD] ? req.period : head.period;
      endcase
      sum     = {1'b0, req.now_time} + {{(TIME_W+1-PERIOD_W){1'b0}}, per_sel};
      sat_sum = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   end

   always_comb begin
      res.next = head;
      res.fire = 1'b0;
      res.due  = head.next_due;
      unique case (req.op)
         OP_TICK: begin
            if (head.valid && head.enabled && (head.next_due != '0) &&
                (head.next_due <= req.now_time)) begin
               res.fire = 1'b1;
               if (head.once) begin
                  // free the slot
                  res.next.valid   = 1'b0;
                  res.next.enabled = 1'b0;
                  res.next.once    = 1'b0;
                  res.due          = '0;
               end else if (head.period != '0) begin
                  res.next.next_due = sat_sum;
                  res.due           = sat_sum;
               end else begin
                  // absolute-only: disable and clear
                  res.next.next_due = '0;
                  res.next.enabled  = 1'b0;
                  res.due           = '0;
               end
            end
         end
         OP_CREATE: begin
            if (sel.take_free) begin
               res.next.valid    = 1'b1;
               res.next.enabled  = req.enable_in;
               res.next.once     = req.once_in;
               res.next.at_time  = req.at_time;
               res.next.period   = req.period;
               res.next.next_due = (req.at_time != '0) ? req.at_time : sat_sum;
               res.due           = res.next.next_due;
            end
         end
         OP_DELETE: begin
            if (sel.hit && head.valid) begin
               res.next.valid   = 1'b0;
               res.next.enabled = 1'b0;
               res.next.once    = 1'b0;
            end
         end
         default: begin
            if (sel.hit && head.valid) begin
               if (req.change_mask[MASK_ENABLE]) res.next.enabled = req.enable_in;
               if (req.change_mask[MASK_ONCE])   res.next.once    = req.once_in;
               res.next.at_time = at_sel;
               res.next.period  = per_sel;
               if (req.change_mask[MASK_AT] || req.change_mask[MASK_PERIOD]) begin
                  if (at_sel != '0)       res.next.next_due = at_sel;
                  else if (per_sel != '0) res.next.next_due = sat_sum;
                  else                    res.next.next_due = '0;
               end
               res.due = res.next.next_due;
            end
         end
      endcase
   end

endmodule
`default_nettype wire
